### hdl/pbc_pkg.sv
package pbc_pkg;

  localparam int CH_W   = 8;
  localparam int W_W    = 16;
  localparam int NUM_W  = 26;
  localparam int DEN_W  = 17;
  localparam int Q_W    = 9;
  localparam int MODE_W = 4;
  localparam int IDX_W  = 4;

  localparam logic [W_W-1:0]   W_FULL   = 16'd65025;
  localparam logic [DEN_W-1:0] DEN_255  = 17'd255;
  localparam logic [DEN_W-1:0] DEN_SOFT = 17'd130050;

  // Division by 65025 of a dividend below 2^24 as floor(x * MIX_RCP / 2^RCP_SH).
  // The dividend is split into two halves of HALF_W bits for the product.
  localparam int HALF_W = 12;
  localparam int RCP_W  = 25;
  localparam int RCP_SH = 40;
  localparam logic [RCP_W-1:0] MIX_RCP = 25'd16909061;

  localparam logic [IDX_W-1:0] CFG_MODE    = 4'd0;
  localparam logic [IDX_W-1:0] CFG_OPACITY = 4'd1;

  localparam logic [MODE_W-1:0] MODE_NORMAL   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MULTIPLY = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SCREEN   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_OVERLAY  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DARKEN   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DODGE    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_BURN     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HARD     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SOFT     = 4'd9;
  localparam logic [MODE_W-1:0] MODE_DIFF     = 4'd10;
  localparam logic [MODE_W-1:0] MODE_EXCL     = 4'd11;

  // How the quotient of the channel divider turns into the blended value.
  typedef enum logic [1:0] {
    OP_DIRECT,
    OP_QUO,
    OP_INV,
    OP_EXCL
  } op_t;

endpackage

### hdl/pbc_in_if.sv
interface pbc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] base_pixel;
  logic [31:0] top_pixel;

  modport source (output valid, output base_pixel, output top_pixel, input ready);
  modport sink (input valid, input base_pixel, input top_pixel, output ready);
endinterface

### hdl/pbc_out_if.sv
interface pbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;

  modport source (output valid, output result_pixel, input ready);
  modport sink (input valid, input result_pixel, output ready);
endinterface

### hdl/pbc_cfg_if.sv
interface pbc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pbc_pkg::IDX_W-1:0]  index;
  logic [7:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/pbc_div.sv
// Restoring divider, one quotient bit per register stage.
module pbc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pbc_pkg::NUM_W-1:0]   num,
  input  logic [pbc_pkg::DEN_W-1:0]   den,
  output logic [pbc_pkg::Q_W-1:0]     quo
);

  logic [pbc_pkg::NUM_W-1:0] rem [pbc_pkg::Q_W];
  logic [pbc_pkg::DEN_W-1:0] dn  [pbc_pkg::Q_W-1];
  logic [pbc_pkg::Q_W-1:0]   qq  [pbc_pkg::Q_W];

  for (genvar s = 0; s < pbc_pkg::Q_W; s++) begin : g_step
    logic [pbc_pkg::NUM_W-1:0] r_in;
    logic [pbc_pkg::DEN_W-1:0] d_in;
    logic [pbc_pkg::Q_W-1:0]   q_in;
    logic [pbc_pkg::NUM_W:0]   trial;
    logic                      take;

    if (s == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign d_in = dn[s-1];
      assign q_in = qq[s-1];
    end

    assign trial = (pbc_pkg::NUM_W+1)'(d_in) << (pbc_pkg::Q_W - 1 - s);
    assign take  = {1'b0, r_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? (r_in - trial[pbc_pkg::NUM_W-1:0]) : r_in;
        qq[s]  <= {q_in[pbc_pkg::Q_W-2:0], take};
      end
    end

    if (s < pbc_pkg::Q_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          dn[s] <= d_in;
        end
      end
    end
  end

  assign quo = qq[pbc_pkg::Q_W-1];

endmodule

### hdl/pixel_blend_composite.sv
// Separable blend of two ARGB8888 pixels followed by source-over compositing.
// The pipeline is the bit-per-stage blend divider plus six register stages
// around it: A and B before it, then C, D, E and the output register.
// Throughput is one word per cycle; the whole pipeline holds while the output
// word waits. Reset (synchronous, active high) empties the pipeline and sets
// the blend mode to normal and the layer opacity to 255.
module pixel_blend_composite (
  input  logic              clk,
  input  logic              rst,
  pbc_in_if.sink            pix_in,
  pbc_out_if.source         pix_out,
  pbc_cfg_if.sink           cfg
);

  localparam int NCH = 3;
  localparam int QW  = pbc_pkg::Q_W;
  localparam int PW  = pbc_pkg::HALF_W + pbc_pkg::RCP_W;
  localparam int SW  = PW + pbc_pkg::HALF_W;

  // Configuration registers. Writes must come only while the pipeline is empty; the block does not enforce this.
  logic [pbc_pkg::MODE_W-1:0] blend_mode;
  logic [7:0]                 layer_opacity;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode    <= pbc_pkg::MODE_NORMAL;
      layer_opacity <= 8'd255;
    end else if (cfg.valid) begin
      if (cfg.index == pbc_pkg::CFG_MODE) begin
        blend_mode <= cfg.data[pbc_pkg::MODE_W-1:0];
      end else if (cfg.index == pbc_pkg::CFG_OPACITY) begin
        layer_opacity <= cfg.data;
      end
    end
  end

  // A single advance strobe moves every stage. The pipeline only stops when
  // the output word is held, so a word enters on every cycle the sink takes one.
  logic adv;
  logic out_v;
  assign adv          = !out_v || pix_out.ready;
  assign pix_in.ready = adv;

  // Stage A: unpack and form the 8x8 products each mode needs.
  logic                  va;
  logic [NCH-1:0][7:0]   a_b, a_t;
  logic [NCH-1:0][15:0]  a_bt, a_bb, a_cc;
  logic [7:0]            a_ba;
  logic [15:0]           a_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) begin
        a_b[ch]  <= pix_in.base_pixel[8*ch +: 8];
        a_t[ch]  <= pix_in.top_pixel[8*ch +: 8];
        a_bt[ch] <= pix_in.base_pixel[8*ch +: 8] * pix_in.top_pixel[8*ch +: 8];
        a_bb[ch] <= pix_in.base_pixel[8*ch +: 8] * pix_in.base_pixel[8*ch +: 8];
        a_cc[ch] <= (8'd255 - pix_in.base_pixel[8*ch +: 8])
                  * (8'd255 - pix_in.top_pixel[8*ch +: 8]);
      end
      a_ba <= pix_in.base_pixel[31:24];
      a_w  <= layer_opacity * pix_in.top_pixel[31:24];
    end
  end

  // Stage B: every mode is reduced to a numerator, a divisor and a rule for
  // turning the quotient into the blended value.
  logic                            vb;
  logic [NCH-1:0][pbc_pkg::NUM_W-1:0] b_num;
  logic [NCH-1:0][pbc_pkg::DEN_W-1:0] b_den;
  pbc_pkg::op_t                    b_op  [NCH];
  logic [NCH-1:0][7:0]             b_dir, b_b, b_t;
  logic [7:0]                      b_ba;
  logic [15:0]                     b_w;

  logic [pbc_pkg::NUM_W-1:0] n_num [NCH];
  logic [pbc_pkg::DEN_W-1:0] n_den [NCH];
  pbc_pkg::op_t              n_op  [NCH];
  logic [7:0]                n_dir [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      logic [pbc_pkg::NUM_W-1:0] bt, cc, sl_num;
      logic [7:0]                b, t;
      b    = a_b[ch];
      t    = a_t[ch];
      bt   = pbc_pkg::NUM_W'(a_bt[ch]);
      cc   = pbc_pkg::NUM_W'(a_cc[ch]);
      // Soft light: 2(255-t)b^2 + 510tb + 65025t over 130050.
      sl_num = (pbc_pkg::NUM_W'(8'd255 - t) * pbc_pkg::NUM_W'(a_bb[ch]) << 1)
             + (bt << 9) - (bt << 1)
             + pbc_pkg::NUM_W'(t) * pbc_pkg::NUM_W'(pbc_pkg::W_FULL);
      n_num[ch] = '0;
      n_den[ch] = pbc_pkg::DEN_255;
      n_op[ch]  = pbc_pkg::OP_DIRECT;
      n_dir[ch] = t;
      case (blend_mode)
        pbc_pkg::MODE_MULTIPLY: begin
          n_num[ch] = bt;
          n_op[ch]  = pbc_pkg::OP_QUO;
        end
        pbc_pkg::MODE_SCREEN: begin
          n_num[ch] = cc;
          n_op[ch]  = pbc_pkg::OP_INV;
        end
        pbc_pkg::MODE_OVERLAY: begin
          n_num[ch] = b[7] ? (cc << 1) : (bt << 1);
          n_op[ch]  = b[7] ? pbc_pkg::OP_INV : pbc_pkg::OP_QUO;
        end
        pbc_pkg::MODE_HARD: begin
          n_num[ch] = t[7] ? (cc << 1) : (bt << 1);
          n_op[ch]  = t[7] ? pbc_pkg::OP_INV : pbc_pkg::OP_QUO;
        end
        pbc_pkg::MODE_DARKEN: begin
          n_dir[ch] = (b < t) ? b : t;
        end
        pbc_pkg::MODE_LIGHTEN: begin
          n_dir[ch] = (b > t) ? b : t;
        end
        pbc_pkg::MODE_DODGE: begin
          if (t == 8'd255) begin
            n_dir[ch] = 8'd255;
          end else begin
            n_num[ch] = pbc_pkg::NUM_W'(b) * pbc_pkg::NUM_W'(8'd255);
            n_den[ch] = pbc_pkg::DEN_W'(8'd255 - t);
            n_op[ch]  = pbc_pkg::OP_QUO;
          end
        end
        pbc_pkg::MODE_BURN: begin
          if (t == 8'd0) begin
            n_dir[ch] = 8'd0;
          end else begin
            n_num[ch] = pbc_pkg::NUM_W'(8'd255 - b) * pbc_pkg::NUM_W'(8'd255);
            n_den[ch] = pbc_pkg::DEN_W'(t);
            n_op[ch]  = pbc_pkg::OP_INV;
          end
        end
        pbc_pkg::MODE_SOFT: begin
          n_num[ch] = sl_num;
          n_den[ch] = pbc_pkg::DEN_SOFT;
          n_op[ch]  = pbc_pkg::OP_QUO;
        end
        pbc_pkg::MODE_DIFF: begin
          n_dir[ch] = (b > t) ? (b - t) : (t - b);
        end
        pbc_pkg::MODE_EXCL: begin
          n_num[ch] = bt << 1;
          n_op[ch]  = pbc_pkg::OP_EXCL;
        end
        default: begin
          n_dir[ch] = t;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) begin
        b_num[ch] <= n_num[ch];
        b_den[ch] <= n_den[ch];
        b_op[ch]  <= n_op[ch];
        b_dir[ch] <= n_dir[ch];
        b_b[ch]   <= a_b[ch];
        b_t[ch]   <= a_t[ch];
      end
      b_ba <= a_ba;
      b_w  <= a_w;
    end
  end

  // Blend dividers, one per color channel. The data that the post stage
  // needs travels beside them in a shift line of the same depth.
  logic [NCH-1:0][QW-1:0] quo;

  for (genvar ch = 0; ch < NCH; ch++) begin : g_bdiv
    pbc_div u_div (
      .clk (clk),
      .en  (adv),
      .num (b_num[ch]),
      .den (b_den[ch]),
      .quo (quo[ch])
    );
  end

  typedef struct packed {
    logic [NCH-1:0][1:0] op;
    logic [NCH-1:0][7:0] dir;
    logic [NCH-1:0][7:0] b;
    logic [NCH-1:0][7:0] t;
    logic [NCH-1:0]      sat;
    logic [7:0]          ba;
    logic [15:0]         w;
  } side_t;

  side_t      side_in;
  side_t      side [QW];
  logic [QW-1:0] vs;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      side_in.op[ch]  = b_op[ch];
      side_in.dir[ch] = b_dir[ch];
      side_in.b[ch]   = b_b[ch];
      side_in.t[ch]   = b_t[ch];
      // A quotient that would not fit in QW bits is flagged as saturated.
      side_in.sat[ch] = {1'b0, b_num[ch]} >= ((pbc_pkg::NUM_W+1)'(b_den[ch]) << QW);
    end
    side_in.ba = b_ba;
    side_in.w  = b_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int s = 1; s < QW; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  // Stage C: turn the quotient into the blended channel value.
  logic                vc;
  logic [NCH-1:0][7:0] c_c, c_b;
  logic [7:0]          c_ba;
  logic [15:0]         c_w;
  logic [7:0]          n_c [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      logic [QW-1:0] qs;
      logic [7:0]    qm;
      logic [QW:0]   ex;
      qs = side[QW-1].sat[ch] ? '1 : quo[ch];
      qm = (qs > QW'(255)) ? 8'd255 : qs[7:0];
      ex = (QW+1)'(side[QW-1].b[ch]) + (QW+1)'(side[QW-1].t[ch])
         - (QW+1)'(quo[ch]);
      case (pbc_pkg::op_t'(side[QW-1].op[ch]))
        pbc_pkg::OP_QUO:  n_c[ch] = qm;
        pbc_pkg::OP_INV:  n_c[ch] = 8'd255 - qm;
        pbc_pkg::OP_EXCL: n_c[ch] = (ex > (QW+1)'(255)) ? 8'd255 : ex[7:0];
        default:          n_c[ch] = side[QW-1].dir[ch];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) begin
        c_c[ch] <= n_c[ch];
        c_b[ch] <= side[QW-1].b[ch];
      end
      c_ba <= side[QW-1].ba;
      c_w  <= side[QW-1].w;
    end
  end

  // Stage D: weighted sum b*(65025-w) + c*w for each channel, and the alpha
  // term with the top value fixed at 255. The sum never exceeds 255*65025.
  logic                vd;
  logic [NCH:0][pbc_pkg::NUM_W-1:0] d_num;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) begin
        d_num[ch] <= pbc_pkg::NUM_W'(c_b[ch]) * pbc_pkg::NUM_W'(pbc_pkg::W_FULL - c_w)
                   + pbc_pkg::NUM_W'(c_c[ch]) * pbc_pkg::NUM_W'(c_w);
      end
      d_num[NCH] <= pbc_pkg::NUM_W'(c_ba) * pbc_pkg::NUM_W'(pbc_pkg::W_FULL - c_w)
                  + pbc_pkg::NUM_W'(c_w) * pbc_pkg::NUM_W'(8'd255);
    end
  end

  // Stage E: division by 65025 as a reciprocal product, alpha in the top lane.
  // The sum fits in 24 bits, and for every such dividend the product shifted
  // right by RCP_SH equals the truncated quotient. Each half of the dividend
  // is multiplied here; the halves are added in front of the output register.
  logic                ve;
  logic [NCH:0][PW-1:0] e_hi, e_lo;
  logic [NCH:0][7:0]   mq;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch <= NCH; ch++) begin
        e_hi[ch] <= PW'(d_num[ch][2*pbc_pkg::HALF_W-1:pbc_pkg::HALF_W])
                  * PW'(pbc_pkg::MIX_RCP);
        e_lo[ch] <= PW'(d_num[ch][pbc_pkg::HALF_W-1:0]) * PW'(pbc_pkg::MIX_RCP);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch <= NCH; ch++) begin
      logic [SW-1:0] prod;
      prod   = (SW'(e_hi[ch]) << pbc_pkg::HALF_W) + SW'(e_lo[ch]);
      mq[ch] = prod[pbc_pkg::RCP_SH +: 8];
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vs    <= '0;
      vc    <= 1'b0;
      vd    <= 1'b0;
      ve    <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      va    <= pix_in.valid;
      vb    <= va;
      vs    <= {vs[QW-2:0], vb};
      vc    <= vs[QW-1];
      vd    <= vc;
      ve    <= vd;
      out_v <= ve;
    end
  end

  // Output register.
  logic [31:0] result;

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= {mq[3], mq[2], mq[1], mq[0]};
    end
  end

  assign pix_out.valid        = out_v;
  assign pix_out.result_pixel = result;

endmodule

### tb/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   err_cnt = 0;
  int   cycle_cnt = 0;

  pbc_in_if  pix_in ();
  pbc_out_if pix_out ();
  pbc_cfg_if cfg ();

  pixel_blend_composite dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  // Drain pauses use a comfortable margin over the pipeline depth.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  // Shadow copy of the two configuration registers.
  logic [pbc_pkg::MODE_W-1:0] cur_mode;
  logic [7:0]                 cur_opacity;

  // Expected result pixels, oldest first.
  logic [31:0] pixel_queue[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter with a hard stop, so a hung handshake cannot run forever.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Blend of one color channel. Every division truncates; the dodge and burn
  // divisions are skipped at a top value of 255 and 0, where they would divide by zero.
  function automatic logic [7:0] blend_value(logic [pbc_pkg::MODE_W-1:0] mode,
                                             logic [7:0] b, logic [7:0] t);
    logic [31:0] bb;
    logic [31:0] tt;
    logic [31:0] c;
    bb = b;
    tt = t;
    case (mode)
      pbc_pkg::MODE_MULTIPLY: c = bb * tt / 255;
      pbc_pkg::MODE_SCREEN:   c = 255 - (255 - bb) * (255 - tt) / 255;
      pbc_pkg::MODE_OVERLAY: begin
        c = (bb < 128) ? 2 * bb * tt / 255 : 255 - 2 * (255 - bb) * (255 - tt) / 255;
      end
      pbc_pkg::MODE_DARKEN:   c = (bb < tt) ? bb : tt;
      pbc_pkg::MODE_LIGHTEN:  c = (bb > tt) ? bb : tt;
      pbc_pkg::MODE_DODGE: begin
        if (tt == 255) c = 255;
        else c = bb * 255 / (255 - tt);
      end
      pbc_pkg::MODE_BURN: begin
        if (tt == 0) c = 0;
        else begin
          c = (255 - bb) * 255 / tt;
          if (c > 255) c = 255;
          c = 255 - c;
        end
      end
      pbc_pkg::MODE_HARD: begin
        c = (tt < 128) ? 2 * bb * tt / 255 : 255 - 2 * (255 - bb) * (255 - tt) / 255;
      end
      pbc_pkg::MODE_SOFT: begin
        c = (2 * (255 - tt) * bb * bb + 510 * tt * bb + 65025 * tt) / 130050;
      end
      pbc_pkg::MODE_DIFF:     c = (bb > tt) ? bb - tt : tt - bb;
      pbc_pkg::MODE_EXCL:     c = bb + tt - 2 * bb * tt / 255;
      default:                c = tt;
    endcase
    if (c > 255) c = 255;
    return c[7:0];
  endfunction

  function automatic logic [7:0] over_mix(logic [7:0] b, logic [7:0] c, logic [31:0] w);
    logic [31:0] v;
    v = ({24'd0, b} * (65025 - w) + {24'd0, c} * w) / 65025;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [31:0] composite_pixel(logic [31:0] base, logic [31:0] top);
    logic [31:0] w;
    logic [31:0] r;
    w = {24'd0, cur_opacity} * {24'd0, top[31:24]};
    r[31:24] = over_mix(base[31:24], 8'd255, w);
    for (int sh = 0; sh < 24; sh += 8) begin
      r[sh +: 8] = over_mix(base[sh +: 8],
                            blend_value(cur_mode, base[sh +: 8], top[sh +: 8]), w);
    end
    return r;
  endfunction

  // Random gap length: mostly none or short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one pixel pair and records its expected result on acceptance.
  // Valid stays high after acceptance; a drain, or a gap in the next call, lowers it.
  task automatic send_pixel(logic [31:0] base, logic [31:0] top, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      pix_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pix_in.valid      <= 1'b1;
    pix_in.base_pixel <= base;
    pix_in.top_pixel  <= top;
    do @(posedge clk); while (!pix_in.ready);
    pixel_queue.push_back(composite_pixel(base, top));
  endtask

  // Waits for every expected word, then DRAIN_CYCLES more, so the block is idle.
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register while the block is idle. Indexes above the opacity
  // register are ignored by the block, so the shadow copy stays unchanged.
  task automatic write_reg(logic [pbc_pkg::IDX_W-1:0] idx, logic [7:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == pbc_pkg::CFG_MODE) cur_mode = value[pbc_pkg::MODE_W-1:0];
    else if (idx == pbc_pkg::CFG_OPACITY) cur_opacity = value;
  endtask

  // Output side: random stalls on ready, and a field compare for each word.
  initial begin
    pix_out.ready <= 1'b0;
    @(negedge rst);
    forever begin
      int g;
      g = gap_len();
      if (g > 0) begin
        pix_out.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
      @(posedge clk);
      if (pix_out.valid) begin
        if (pixel_queue.size() == 0) begin
          $error("result_pixel: unexpected word %h", pix_out.result_pixel);
          err_cnt++;
        end else begin
          logic [31:0] exp_pix;
          exp_pix = pixel_queue.pop_front();
          if (pix_out.result_pixel !== exp_pix) begin
            $error("result_pixel: expected %h actual %h", exp_pix, pix_out.result_pixel);
            err_cnt++;
          end
        end
      end
    end
  end

  // Directed corners: channel extremes under the reset settings, dodge and burn
  // division corners, soft light saturation, mode 15, opacity 0 and index 7.
  task automatic test_directed();
    send_pixel(32'h00000000, 32'h00000000, 0);
    send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_pixel(32'h00FFFFFF, 32'hFF000000, 0);
    send_pixel(32'hFF000000, 32'h80FFFFFF, 0);
    send_pixel(32'h7F807F80, 32'hFF7F807F, 0);
    write_reg(pbc_pkg::CFG_MODE, 8'(pbc_pkg::MODE_DODGE));
    send_pixel(32'hFF00FF80, 32'hFFFFFFFF, 0);
    send_pixel(32'hFF00FF80, 32'hFFFE0001, 0);
    write_reg(pbc_pkg::CFG_MODE, 8'(pbc_pkg::MODE_BURN));
    send_pixel(32'hFF00FF80, 32'hFF000000, 0);
    send_pixel(32'hFF00FF80, 32'hFF01FFFE, 0);
    write_reg(pbc_pkg::CFG_MODE, 8'(pbc_pkg::MODE_SOFT));
    send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_pixel(32'hFFFFFE80, 32'hFFFF7F01, 0);
    write_reg(pbc_pkg::CFG_MODE, 8'd15);
    send_pixel(32'hFF123456, 32'hFF654321, 0);
    write_reg(pbc_pkg::CFG_OPACITY, 8'd0);
    send_pixel(32'h80123456, 32'hFF654321, 0);
    write_reg(4'd7, 8'd3);
    send_pixel(32'h80123456, 32'hFF654321, 0);
  endtask

  // Every mode, including unused codes, at each of several opacities.
  task automatic test_modes_random();
    logic [7:0] opac_set[5] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254};
    foreach (opac_set[k]) begin
      write_reg(pbc_pkg::CFG_OPACITY, opac_set[k]);
      for (int m = 0; m < 16; m++) begin
        write_reg(pbc_pkg::CFG_MODE, m[7:0]);
        for (int n = 0; n < 9; n++) begin
          logic [31:0] tp;
          tp = $urandom();
          if ($urandom_range(0, 3) == 0) tp[31:24] = 8'hFF;
          send_pixel($urandom(), tp, 1'b1);
        end
      end
    end
  endtask

  // Back-to-back burst with no source gaps, then a full drain before more.
  task automatic test_burst();
    write_reg(pbc_pkg::CFG_OPACITY, 8'($urandom_range(0, 255)));
    write_reg(pbc_pkg::CFG_MODE, 8'($urandom_range(0, 11)));
    for (int n = 0; n < 30; n++) send_pixel($urandom(), $urandom(), 1'b0);
    drain();
    for (int n = 0; n < 10; n++) send_pixel($urandom(), $urandom(), 1'b1);
  endtask

  initial begin
    cur_mode     = pbc_pkg::MODE_NORMAL;
    cur_opacity  = 8'd255;
    rst          = 1'b1;
    pix_in.valid <= 1'b0;
    pix_in.base_pixel <= '0;
    pix_in.top_pixel  <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_modes_random();
    test_burst();
    drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
